FILE: rtl/core/planar_three_link_forward_kinematics_defines.svh
// Assertion macros shared by the planar three-link kinematics RTL.
`ifndef PLANAR_THREE_LINK_FORWARD_KINEMATICS_DEFINES_SVH
`define PLANAR_THREE_LINK_FORWARD_KINEMATICS_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PTLFK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication with a fixed delay in clock cycles.
`define PTLFK_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ptlfk_pkg.sv
// Shared types, constants and the arctangent table of the kinematics pipeline.
package ptlfk_pkg;

  localparam int ANG_W = 16;
  localparam int LEN_W = 10;
  localparam int OUT_W = 17;
  localparam int NLANES = 3;

  localparam int CW = 32;
  localparam int ZW = 32;
  localparam int OFF_W = 18;
  localparam int SUM_W = 19;
  localparam int RES_W = 13;
  localparam int Z_FRAC = 18;
  localparam int QUO_BITS = 6;
  localparam int PROD_W = CW + LEN_W + 1;
  localparam int ACC_W = PROD_W + 2;
  localparam int OUT_SHIFT = 26;

  localparam int QUARTER_TURN = 5760;
  localparam int ANGLE_OFFSET = 120960;
  localparam int CORDIC_GAIN = 652032874;
  localparam int ROUND_HALF = 33554432;
  localparam int ATAN_ENTRIES = 24;

  localparam logic [1:0] QUAD_I = 2'd0;
  localparam logic [1:0] QUAD_II = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV = 2'd3;

  typedef struct packed {
    logic [1:0] quad;
    logic signed [ZW-1:0] z;
  } ptlfk_angle_t;

  typedef struct packed {
    logic [1:0] quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } ptlfk_rot_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      0: val = 32'sd754974720;
      1: val = 32'sd445687602;
      2: val = 32'sd235489088;
      3: val = 32'sd119537938;
      4: val = 32'sd60000934;
      5: val = 32'sd30029717;
      6: val = 32'sd15018523;
      7: val = 32'sd7509720;
      8: val = 32'sd3754917;
      9: val = 32'sd1877466;
      10: val = 32'sd938734;
      11: val = 32'sd469367;
      12: val = 32'sd234683;
      13: val = 32'sd117342;
      14: val = 32'sd58671;
      15: val = 32'sd29335;
      16: val = 32'sd14668;
      17: val = 32'sd7334;
      18: val = 32'sd3667;
      19: val = 32'sd1833;
      20: val = 32'sd917;
      21: val = 32'sd458;
      22: val = 32'sd229;
      23: val = 32'sd115;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/core/planar_three_link_forward_kinematics.sv
// Top level of the planar three-link arm forward kinematics pipeline.
// The block takes one request in every clock cycle and never raises busy. Each
// request returns its tip position once it has passed the angle reduction, CORDIC
// and combine stages (16 CORDIC stages by default, at most 24 stages run),
// with out_valid high for one cycle; results come out in request order and the
// receiver has to take them as they appear. The pipeline holds the CORDIC
// stages, one per rotation, plus two stages of angle reduction and three
// of quadrant mapping, multiplication and rounding. Link lengths are written
// through the cfg port and should change only while no request is in flight.
`include "planar_three_link_forward_kinematics_defines.svh"

module planar_three_link_forward_kinematics #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ptlfk_pkg::ANG_W-1:0]   in_shoulder_angle,
  input  logic signed [ptlfk_pkg::ANG_W-1:0]   in_elbow_angle,
  input  logic signed [ptlfk_pkg::ANG_W-1:0]   in_wrist_angle,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [ptlfk_pkg::LEN_W-1:0]          cfg_data,
  output logic                                 out_valid,
  output logic signed [ptlfk_pkg::OUT_W-1:0]   out_tip_x,
  output logic signed [ptlfk_pkg::OUT_W-1:0]   out_tip_y
);
  import ptlfk_pkg::*;

  localparam int RUN = (ROTATION_STAGES < ATAN_ENTRIES) ? ROTATION_STAGES : ATAN_ENTRIES;
  localparam int LAT = RUN + 5;
  localparam logic signed [ZW-1:0] ZMAX = ZW'(QUARTER_TURN) <<< Z_FRAC;

  localparam logic [1:0] REG_LINK1 = 2'd0;
  localparam logic [1:0] REG_LINK2 = 2'd1;
  localparam logic [1:0] REG_LINK3 = 2'd2;

  logic [LEN_W-1:0] link1_len_r;
  logic [LEN_W-1:0] link2_len_r;
  logic [LEN_W-1:0] link3_len_r;

  logic                      req;
  logic                      ang_valid;
  ptlfk_angle_t [NLANES-1:0] ang;
  logic                      rot_valid;
  ptlfk_rot_t [NLANES-1:0]   rot;
  logic [NLANES-1:0][LEN_W-1:0] link_len;
  logic                      resid_ok;

  assign busy = 1'b0;
  assign req = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link1_len_r <= LEN_W'(145);
      link2_len_r <= LEN_W'(125);
      link3_len_r <= LEN_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINK1: link1_len_r <= cfg_data;
        REG_LINK2: link2_len_r <= cfg_data;
        REG_LINK3: link3_len_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign link_len[0] = link1_len_r;
  assign link_len[1] = link2_len_r;
  assign link_len[2] = link3_len_r;

  ptlfk_angle_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (req),
    .shoulder (in_shoulder_angle),
    .elbow    (in_elbow_angle),
    .wrist    (in_wrist_angle),
    .out_valid(ang_valid),
    .out_ang  (ang)
  );

  ptlfk_cordic #(
    .STAGES(RUN)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (ang_valid),
    .in_ang   (ang),
    .out_valid(rot_valid),
    .out_rot  (rot)
  );

  ptlfk_combine u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rot_valid),
    .in_rot   (rot),
    .link_len (link_len),
    .out_valid(out_valid),
    .out_tip_x(out_tip_x),
    .out_tip_y(out_tip_y)
  );

  assign resid_ok = (ang[0].z >= 0) && (ang[0].z < ZMAX)
                 && (ang[1].z >= 0) && (ang[1].z < ZMAX)
                 && (ang[2].z >= 0) && (ang[2].z < ZMAX);

  `PTLFK_ASSERT_DELAY(a_req_gives_result, req, LAT, out_valid, "request produced no result")
  `PTLFK_ASSERT_IMPL(a_result_has_req, out_valid, $past(req, LAT), "result without request")
  `PTLFK_ASSERT_IMPL(a_residual_range, ang_valid, resid_ok, "residual angle outside quadrant")

endmodule

FILE: rtl/core/ptlfk_angle_reduce.sv
// Link angle sums and reduction to quadrant plus residual angle, two stages.
module ptlfk_angle_reduce (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  logic signed [ptlfk_pkg::ANG_W-1:0]        shoulder,
  input  logic signed [ptlfk_pkg::ANG_W-1:0]        elbow,
  input  logic signed [ptlfk_pkg::ANG_W-1:0]        wrist,
  output logic                                      out_valid,
  output ptlfk_pkg::ptlfk_angle_t [ptlfk_pkg::NLANES-1:0] out_ang
);
  import ptlfk_pkg::*;

  localparam logic [OFF_W-1:0] DIV_BASE = OFF_W'(QUARTER_TURN);

  logic                    sa_valid_r;
  logic [OFF_W-1:0]        off_r [NLANES];
  logic [OFF_W-1:0]        off_nxt [NLANES];
  logic signed [SUM_W-1:0] v1, v2, v3;

  logic                    sb_valid_r;
  ptlfk_angle_t [NLANES-1:0] ang_r;
  ptlfk_angle_t [NLANES-1:0] ang_nxt;

  // The offset of a right angle plus five full turns keeps every sum positive.
  always_comb begin
    v1 = SUM_W'(ANGLE_OFFSET) - SUM_W'(shoulder);
    v2 = v1 - SUM_W'(elbow);
    v3 = v2 - SUM_W'(wrist);
    off_nxt[0] = v1[OFF_W-1:0];
    off_nxt[1] = v2[OFF_W-1:0];
    off_nxt[2] = v3[OFF_W-1:0];
  end

  always_comb begin
    logic [OFF_W-1:0] rem;
    logic [OFF_W-1:0] dv;
    logic [1:0]       quad;
    for (int l = 0; l < NLANES; l++) begin
      rem = off_r[l];
      quad = '0;
      for (int k = QUO_BITS - 1; k >= 0; k--) begin
        dv = DIV_BASE << k;
        if (rem >= dv) begin
          rem = rem - dv;
          quad = {quad[0], 1'b1};
        end else begin
          quad = {quad[0], 1'b0};
        end
      end
      ang_nxt[l].quad = quad;
      ang_nxt[l].z = {1'b0, rem[RES_W-1:0], {Z_FRAC{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
      sb_valid_r <= 1'b0;
    end else begin
      sa_valid_r <= in_valid;
      sb_valid_r <= sa_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NLANES; l++) begin
      off_r[l] <= off_nxt[l];
    end
    ang_r <= ang_nxt;
  end

  assign out_valid = sb_valid_r;
  assign out_ang = ang_r;

endmodule

FILE: rtl/core/ptlfk_cordic.sv
// Rotation-mode CORDIC pipeline, one register stage per iteration, three lanes.
module ptlfk_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  ptlfk_pkg::ptlfk_angle_t [ptlfk_pkg::NLANES-1:0] in_ang,
  output logic                                      out_valid,
  output ptlfk_pkg::ptlfk_rot_t [ptlfk_pkg::NLANES-1:0]   out_rot
);
  import ptlfk_pkg::*;

  logic                 vld_r [STAGES];
  logic signed [CW-1:0] x_r [STAGES][NLANES];
  logic signed [CW-1:0] y_r [STAGES][NLANES];
  logic signed [ZW-1:0] z_r [STAGES][NLANES];
  logic [1:0]           q_r [STAGES][NLANES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = atan_q24(i);

    logic                 vs;
    logic signed [CW-1:0] xs [NLANES];
    logic signed [CW-1:0] ys [NLANES];
    logic signed [ZW-1:0] zs [NLANES];
    logic [1:0]           qs [NLANES];
    logic signed [CW-1:0] x_nxt [NLANES];
    logic signed [CW-1:0] y_nxt [NLANES];
    logic signed [ZW-1:0] z_nxt [NLANES];

    if (i == 0) begin : g_src_in
      assign vs = in_valid;
      for (genvar l = 0; l < NLANES; l++) begin : g_lane
        assign xs[l] = CW'(CORDIC_GAIN);
        assign ys[l] = '0;
        assign zs[l] = in_ang[l].z;
        assign qs[l] = in_ang[l].quad;
      end
    end else begin : g_src_prev
      assign vs = vld_r[i-1];
      for (genvar l = 0; l < NLANES; l++) begin : g_lane
        assign xs[l] = x_r[i-1][l];
        assign ys[l] = y_r[i-1][l];
        assign zs[l] = z_r[i-1][l];
        assign qs[l] = q_r[i-1][l];
      end
    end

    always_comb begin
      for (int l = 0; l < NLANES; l++) begin
        if (zs[l] >= 0) begin
          x_nxt[l] = xs[l] - (ys[l] >>> i);
          y_nxt[l] = ys[l] + (xs[l] >>> i);
          z_nxt[l] = zs[l] - AT;
        end else begin
          x_nxt[l] = xs[l] + (ys[l] >>> i);
          y_nxt[l] = ys[l] - (xs[l] >>> i);
          z_nxt[l] = zs[l] + AT;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vs;
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < NLANES; l++) begin
        x_r[i][l] <= x_nxt[l];
        y_r[i][l] <= y_nxt[l];
        z_r[i][l] <= z_nxt[l];
        q_r[i][l] <= qs[l];
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];

  for (genvar l = 0; l < NLANES; l++) begin : g_out
    assign out_rot[l].quad = q_r[STAGES-1][l];
    assign out_rot[l].x = x_r[STAGES-1][l];
    assign out_rot[l].y = y_r[STAGES-1][l];
  end

endmodule

FILE: rtl/core/ptlfk_combine.sv
// Quadrant mapping, length products and rounded sums of the three links.
module ptlfk_combine (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  ptlfk_pkg::ptlfk_rot_t [ptlfk_pkg::NLANES-1:0] in_rot,
  input  logic [ptlfk_pkg::NLANES-1:0][ptlfk_pkg::LEN_W-1:0] link_len,
  output logic                                    out_valid,
  output logic signed [ptlfk_pkg::OUT_W-1:0]      out_tip_x,
  output logic signed [ptlfk_pkg::OUT_W-1:0]      out_tip_y
);
  import ptlfk_pkg::*;

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(ROUND_HALF);

  logic                     mv_r;
  logic signed [CW-1:0]     c_r [NLANES];
  logic signed [CW-1:0]     s_r [NLANES];
  logic signed [CW-1:0]     c_nxt [NLANES];
  logic signed [CW-1:0]     s_nxt [NLANES];

  logic                     pv_r;
  logic signed [PROD_W-1:0] pc_r [NLANES];
  logic signed [PROD_W-1:0] ps_r [NLANES];

  logic                     ov_r;
  logic signed [OUT_W-1:0]  tip_x_r;
  logic signed [OUT_W-1:0]  tip_y_r;
  logic signed [ACC_W-1:0]  sum_x;
  logic signed [ACC_W-1:0]  sum_y;

  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      unique case (in_rot[l].quad)
        QUAD_I: begin
          c_nxt[l] = in_rot[l].x;
          s_nxt[l] = in_rot[l].y;
        end
        QUAD_II: begin
          c_nxt[l] = -in_rot[l].y;
          s_nxt[l] = in_rot[l].x;
        end
        QUAD_III: begin
          c_nxt[l] = -in_rot[l].x;
          s_nxt[l] = -in_rot[l].y;
        end
        QUAD_IV: begin
          c_nxt[l] = in_rot[l].y;
          s_nxt[l] = -in_rot[l].x;
        end
        default: begin
          c_nxt[l] = in_rot[l].x;
          s_nxt[l] = in_rot[l].y;
        end
      endcase
    end
  end

  always_comb begin
    sum_x = ACC_W'(pc_r[0]) + ACC_W'(pc_r[1]) + ACC_W'(pc_r[2]) + RND;
    sum_y = ACC_W'(ps_r[0]) + ACC_W'(ps_r[1]) + ACC_W'(ps_r[2]) + RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      pv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      mv_r <= in_valid;
      pv_r <= mv_r;
      ov_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NLANES; l++) begin
      c_r[l] <= c_nxt[l];
      s_r[l] <= s_nxt[l];
      pc_r[l] <= $signed({1'b0, link_len[l]}) * c_r[l];
      ps_r[l] <= $signed({1'b0, link_len[l]}) * s_r[l];
    end
    tip_x_r <= sum_x[OUT_SHIFT+OUT_W-1:OUT_SHIFT];
    tip_y_r <= sum_y[OUT_SHIFT+OUT_W-1:OUT_SHIFT];
  end

  assign out_valid = ov_r;
  assign out_tip_x = tip_x_r;
  assign out_tip_y = tip_y_r;

endmodule

FILE: tb/fk_tip_scoreboard.sv
// Scoreboard package: link-register codes and the tip position predictor and checker.
`timescale 1ns / 100ps

package fk_tb_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_COUNT = 24;
  localparam int TURN_360 = 23040;
  localparam int TURN_90 = 5760;
  localparam int RIGHT_ANGLE = 90 * 64;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint HALF_LSB = 64'sd33554432;
  localparam int TIP_SHIFT = 26;
  localparam int MAX_PRINTED = 100;

  localparam longint ATAN_DEG_Q24[ATAN_COUNT] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234683, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115
  };

  typedef enum logic [1:0] {
    REG_LINK1 = 2'd0,
    REG_LINK2 = 2'd1,
    REG_LINK3 = 2'd2,
    REG_UNUSED = 2'd3
  } link_reg_e;

  typedef struct {
    logic signed [ptlfk_pkg::OUT_W-1:0] x;
    logic signed [ptlfk_pkg::OUT_W-1:0] y;
  } tip_pos_t;

  class tip_position_checker;
    int link_len[3];
    tip_pos_t pending_tips[$];
    int errors;
    int n_checked;

    function new();
      link_len[REG_LINK1] = 145;
      link_len[REG_LINK2] = 125;
      link_len[REG_LINK3] = 128;
      errors = 0;
      n_checked = 0;
    endfunction

    function void set_length(link_reg_e idx, int value);
      if (idx != REG_UNUSED) begin
        link_len[idx] = value & 10'h3FF;
      end
    endfunction

    function int pending_count();
      return pending_tips.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("%0t: MISMATCH %s", $time, msg);
      end
    endtask

    // CORDIC rotation of the angle inside its quadrant, then mapped back out.
    function automatic void link_sin_cos(input int angle, output longint cosv,
                                         output longint sinv);
      int a;
      int q;
      int r;
      longint x;
      longint y;
      longint z;
      longint nx;
      longint ny;
      a = angle % TURN_360;
      if (a < 0) begin
        a += TURN_360;
      end
      q = a / TURN_90;
      r = a - q * TURN_90;
      x = GAIN_Q30;
      y = 0;
      z = longint'(r) * 262144;
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_COUNT; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z -= ATAN_DEG_Q24[i];
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z += ATAN_DEG_Q24[i];
        end
        x = nx;
        y = ny;
      end
      case (q)
        0: begin
          cosv = x;
          sinv = y;
        end
        1: begin
          cosv = -y;
          sinv = x;
        end
        2: begin
          cosv = -x;
          sinv = -y;
        end
        default: begin
          cosv = y;
          sinv = -x;
        end
      endcase
    endfunction

    function void note_request(int shoulder, int elbow, int wrist);
      int ang[3];
      longint c;
      longint s;
      longint sx;
      longint sy;
      longint rx;
      longint ry;
      tip_pos_t tip;
      ang[0] = RIGHT_ANGLE - shoulder;
      ang[1] = ang[0] - elbow;
      ang[2] = ang[1] - wrist;
      sx = 0;
      sy = 0;
      for (int k = 0; k < 3; k++) begin
        link_sin_cos(ang[k], c, s);
        sx += longint'(link_len[k]) * c;
        sy += longint'(link_len[k]) * s;
      end
      rx = (sx + HALF_LSB) >>> TIP_SHIFT;
      ry = (sy + HALF_LSB) >>> TIP_SHIFT;
      tip.x = rx[ptlfk_pkg::OUT_W-1:0];
      tip.y = ry[ptlfk_pkg::OUT_W-1:0];
      pending_tips.push_back(tip);
    endfunction

    task check_result(logic signed [ptlfk_pkg::OUT_W-1:0] x,
                      logic signed [ptlfk_pkg::OUT_W-1:0] y);
      tip_pos_t want;
      if (pending_tips.size() == 0) begin
        report($sformatf("result x=%0d y=%0d with no request outstanding", x, y));
      end else begin
        want = pending_tips.pop_front();
        n_checked++;
        if (x !== want.x) begin
          report($sformatf("tip_x got %0d, expected %0d", x, want.x));
        end
        if (y !== want.y) begin
          report($sformatf("tip_y got %0d, expected %0d", y, want.y));
        end
      end
    endtask

    task flush_check();
      if (pending_tips.size() != 0) begin
        report($sformatf("%0d results never arrived", pending_tips.size()));
      end
    endtask
  endclass

endpackage

FILE: tb/tb.sv
// Top-level testbench for the planar three-link forward kinematics block.
`timescale 1ns / 100ps

module tb;
  import fk_tb_pkg::*;

  localparam int LATENCY = CORDIC_STAGES + 5;
  localparam int STALL_LIMIT = 2000;
  localparam int N_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int RANDOM_LEN = -1;
  localparam int N_DIRECTED = 21;

  localparam int DIRECTED[N_DIRECTED][3] = '{
    '{0, 0, 0}, '{-32768, -32768, -32768}, '{32767, 32767, 32767},
    '{23040, 23040, 23040}, '{-23040, -23040, -23040}, '{5760, 0, 0},
    '{5759, 1, 0}, '{5761, -1, 0}, '{11520, 0, 0}, '{17280, 0, 0},
    '{-5760, 5760, -5760}, '{0, 5760, 5760}, '{0, -11520, 0}, '{0, 0, -17280},
    '{-32768, 32767, 0}, '{32767, -32768, -1}, '{1, 1, 1}, '{-1, -1, -1},
    '{2880, 2880, 2880}, '{4096, -8192, 16384}, '{21, -300, 7000}
  };
  localparam int PHASE_IDLE[N_PHASES] = '{0, 76, 0, 25, 76};
  localparam int PHASE_LEN[N_PHASES][3] = '{
    '{1023, 1023, 1023}, '{0, 0, 0}, '{RANDOM_LEN, RANDOM_LEN, RANDOM_LEN},
    '{RANDOM_LEN, RANDOM_LEN, RANDOM_LEN}, '{1, 1023, 0}
  };

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [ptlfk_pkg::ANG_W-1:0] in_shoulder_angle;
  logic signed [ptlfk_pkg::ANG_W-1:0] in_elbow_angle;
  logic signed [ptlfk_pkg::ANG_W-1:0] in_wrist_angle;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [ptlfk_pkg::LEN_W-1:0] cfg_data;
  logic out_valid;
  logic signed [ptlfk_pkg::OUT_W-1:0] out_tip_x;
  logic signed [ptlfk_pkg::OUT_W-1:0] out_tip_y;

  tip_position_checker tips;
  int n_requests;
  int n_settings;
  int stall_cycles;

  planar_three_link_forward_kinematics #(
    .ROTATION_STAGES(CORDIC_STAGES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_shoulder_angle(in_shoulder_angle),
    .in_elbow_angle(in_elbow_angle),
    .in_wrist_angle(in_wrist_angle),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_tip_x(out_tip_x),
    .out_tip_y(out_tip_y)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        tips.note_request(int'(in_shoulder_angle), int'(in_elbow_angle),
                          int'(in_wrist_angle));
        n_requests++;
      end
      if (out_valid) begin
        tips.check_result(out_tip_x, out_tip_y);
      end
      if ((start && !busy) || out_valid) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", stall_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int random_angle();
    logic [15:0] raw;
    raw = 16'($urandom);
    case ($urandom_range(0, 3))
      0: return int'($signed(raw));
      1: return int'($urandom_range(0, 46080)) - 23040;
      2: return (int'($urandom_range(0, 8)) - 4) * TURN_90 + int'($urandom_range(0, 4)) - 2;
      default: return int'($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  task drive_request(input int shoulder, input int elbow, input int wrist,
                     input int idle_pct);
    int gap;
    gap = 0;
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_shoulder_angle <= shoulder[15:0];
    in_elbow_angle <= elbow[15:0];
    in_wrist_angle <= wrist[15:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (tips.pending_count() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task write_reg(input link_reg_e idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[ptlfk_pkg::LEN_W-1:0];
    @(posedge clk);
    tips.set_length(idx, value);
  endtask

  task program_links(input int l1, input int l2, input int l3);
    write_reg(REG_LINK1, l1);
    write_reg(REG_LINK2, l2);
    write_reg(REG_LINK3, l3);
    // A write to the spare index must leave every length untouched.
    write_reg(REG_UNUSED, int'($urandom_range(0, 1023)));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int lens[3];
    tips = new();
    n_requests = 0;
    n_settings = 1;
    stall_cycles = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_shoulder_angle <= '0;
    in_elbow_angle <= '0;
    in_wrist_angle <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_LINK1;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int d = 0; d < N_DIRECTED; d++) begin
      drive_request(DIRECTED[d][0], DIRECTED[d][1], DIRECTED[d][2], 0);
    end
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      for (int k = 0; k < 3; k++) begin
        lens[k] = (PHASE_LEN[p][k] == RANDOM_LEN) ? int'($urandom_range(0, 1023))
                                                  : PHASE_LEN[p][k];
      end
      program_links(lens[0], lens[1], lens[2]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        drive_request(random_angle(), random_angle(), random_angle(), PHASE_IDLE[p]);
      end
      drain();
    end

    tips.flush_check();
    $display("Run covered %0d requests and %0d checked tip positions", n_requests,
             tips.n_checked);
    $display("over %0d link-length settings, with sender idling from none to 76 percent.",
             n_settings);
    if (tips.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
